// File: rtl/int8_dot_product_requantize_unit_macros.svh
// assertion macros for the int8 dot product requantize unit
// used by the top level only, no other dependencies
`ifndef INT8_DOT_PRODUCT_REQUANTIZE_UNIT_MACROS_SVH
`define INT8_DOT_PRODUCT_REQUANTIZE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define IDPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idpr assertion failed");

// next-cycle implication, disabled in reset
`define IDPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idpr assertion failed");

`endif

// File: rtl/idpr_pkg.sv
// shared types and constants for the int8 dot product requantize unit
// no dependencies
`timescale 1ns / 1ps

package idpr_pkg;

    localparam int PACK_W     = 64;
    localparam int ELEM_W     = 8;
    localparam int MAX_LANES  = 8;
    localparam int PROD_W     = 16;
    localparam int PSUM_W     = 20;
    localparam int ACC_W      = 32;
    localparam int QUANT_W    = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    // requantize scale 127/16129 reduces to a divide by 127
    localparam int DIVISOR    = 127;
    // remainder after the shift-add quotient estimate stays below 6 * 127
    localparam int CORR_STEPS = 5;
    localparam int REM_W      = 11;

    typedef struct packed {
        logic [PACK_W-1:0] matrix_pack;
        logic [PACK_W-1:0] vector_pack;
        logic              last_in_row;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0]   row_sum;
        logic signed [QUANT_W-1:0] row_quantized;
    } t_out_item;

    typedef struct packed {
        logic                    push;
        logic signed [ACC_W-1:0] row_sum;
    } t_row_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// File: rtl/idpr_front.sv
// front end: lane multipliers, pack sum and row accumulator
// depends on idpr_pkg
`timescale 1ns / 1ps

module idpr_front #(
    parameter int LANES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  idpr_pkg::t_in_item i_item,
    input  logic              i_fifo_full,
    output logic              o_full,
    output idpr_pkg::t_row_wr o_wr
);

    logic                                    r_s1_valid;
    logic                                    r_s1_last;
    logic signed [idpr_pkg::PROD_W-1:0]      r_s1_prod [LANES];
    logic                                    r_s2_valid;
    logic                                    r_s2_last;
    logic signed [idpr_pkg::PSUM_W-1:0]      r_s2_psum;
    logic signed [idpr_pkg::ACC_W-1:0]       r_acc;

    logic signed [idpr_pkg::PROD_W-1:0]      n_prod [LANES];
    logic signed [idpr_pkg::PSUM_W-1:0]      n_psum;
    logic signed [idpr_pkg::ACC_W-1:0]       w_total;
    logic                                    w_stall;
    logic                                    w_adv;

    // hold the whole front while a finished row waits for queue room
    assign w_stall = r_s2_valid & r_s2_last & i_fifo_full;
    assign w_adv   = ~w_stall;
    assign o_full  = w_stall;

    // lane products
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_prod[k] = $signed(i_item.matrix_pack[idpr_pkg::ELEM_W*k +: idpr_pkg::ELEM_W])
                      * $signed(i_item.vector_pack[idpr_pkg::ELEM_W*k +: idpr_pkg::ELEM_W]);
        end
    end

    // pack sum over the registered products
    always_comb begin
        n_psum = '0;
        for (int k = 0; k < LANES; k++) begin
            n_psum = n_psum + idpr_pkg::PSUM_W'(r_s1_prod[k]);
        end
    end

    // row total including the pack in stage two
    assign w_total = r_acc + idpr_pkg::ACC_W'(r_s2_psum);

    // finished row goes to the queue
    assign o_wr.push    = r_s2_valid & r_s2_last & ~i_fifo_full;
    assign o_wr.row_sum = w_total;

    // control and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc      <= '0;
        end else if (w_adv) begin
            r_s1_valid <= i_push;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                r_acc <= r_s2_last ? '0 : w_total;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last <= i_item.last_in_row;
            r_s1_prod <= n_prod;
            r_s2_last <= r_s1_last;
            r_s2_psum <= n_psum;
        end
    end

endmodule

// File: rtl/idpr_fifo.sv
// short queue of finished row sums between front and back
// depends on idpr_pkg
`timescale 1ns / 1ps

module idpr_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  idpr_pkg::t_row_wr                  i_wr,
    input  logic                               i_pop,
    output idpr_pkg::t_fifo_status             o_status,
    output logic signed [idpr_pkg::ACC_W-1:0]  o_row_sum
);

    logic signed [idpr_pkg::ACC_W-1:0] r_mem [idpr_pkg::FIFO_DEPTH];
    logic [idpr_pkg::FIFO_AW-1:0]      r_wr_ptr;
    logic [idpr_pkg::FIFO_AW-1:0]      r_rd_ptr;
    logic [idpr_pkg::FIFO_AW:0]        r_count;
    logic                              w_push;
    logic                              w_pop;

    assign o_status.full  = (r_count == (idpr_pkg::FIFO_AW+1)'(idpr_pkg::FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_wr.push & ~o_status.full;
    assign w_pop          = i_pop & ~o_status.empty;
    assign o_row_sum      = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.row_sum;
        end
    end

endmodule

// File: rtl/idpr_back.sv
// back end: divide by 127 toward zero in four stages, result register
// depends on idpr_pkg
`timescale 1ns / 1ps

module idpr_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  idpr_pkg::t_fifo_status             i_fifo_status,
    input  logic signed [idpr_pkg::ACC_W-1:0]  i_row_sum,
    input  logic                               i_pop,
    output logic                               o_fifo_pop,
    output logic                               o_empty,
    output idpr_pkg::t_out_item                o_item
);

    logic                               r_b1_valid;
    logic signed [idpr_pkg::ACC_W-1:0]  r_b1_sum;
    logic                               r_b1_neg;
    logic [idpr_pkg::ACC_W-1:0]         r_b1_abs;
    logic                               r_b2_valid;
    logic signed [idpr_pkg::ACC_W-1:0]  r_b2_sum;
    logic                               r_b2_neg;
    logic [idpr_pkg::REM_W-1:0]         r_b2_alow;
    logic [idpr_pkg::REM_W-1:0]         r_b2_q0;
    logic                               r_b3_valid;
    logic signed [idpr_pkg::ACC_W-1:0]  r_b3_sum;
    logic                               r_b3_neg;
    logic [idpr_pkg::REM_W-1:0]         r_b3_rem;
    logic [idpr_pkg::QUANT_W-1:0]       r_b3_q0;
    logic                               r_out_valid;
    idpr_pkg::t_out_item                r_out;

    logic                               w_adv;
    logic                               w_take;
    logic [idpr_pkg::ACC_W-1:0]         n_abs;
    logic [idpr_pkg::ACC_W-1:0]         n_q0;
    logic [idpr_pkg::REM_W-1:0]         n_rem;
    logic [2:0]                         n_corr;
    logic [idpr_pkg::QUANT_W-1:0]       n_q;
    logic [idpr_pkg::QUANT_W-1:0]       n_quant;

    assign w_adv      = ~r_out_valid | i_pop;
    assign w_take     = w_adv & ~i_fifo_status.empty;
    assign o_fifo_pop = w_take;
    assign o_empty    = ~r_out_valid;
    assign o_item     = r_out;

    // magnitude, the most negative sum maps to 2^31 unsigned
    assign n_abs = i_row_sum[idpr_pkg::ACC_W-1] ? (~i_row_sum + 1'b1) : i_row_sum;

    // quotient estimate from 1/127 = 2^-7 + 2^-14 + 2^-21 + 2^-28 + ...
    assign n_q0 = (r_b1_abs >> 7) + (r_b1_abs >> 14) + (r_b1_abs >> 21) + (r_b1_abs >> 28);

    // small remainder of the estimate, exact in the low bits
    assign n_rem = r_b2_alow - (r_b2_q0 << 7) + r_b2_q0;

    // correction count, then sign and wrap to eight bits
    always_comb begin
        n_corr = '0;
        for (int k = 1; k <= idpr_pkg::CORR_STEPS; k++) begin
            if (r_b3_rem >= idpr_pkg::REM_W'(idpr_pkg::DIVISOR * k)) begin
                n_corr = n_corr + 1'b1;
            end
        end
        n_q     = r_b3_q0 + idpr_pkg::QUANT_W'(n_corr);
        n_quant = r_b3_neg ? (~n_q + 1'b1) : n_q;
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b1_valid  <= w_take;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_out_valid <= r_b3_valid;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b1_sum  <= i_row_sum;
            r_b1_neg  <= i_row_sum[idpr_pkg::ACC_W-1];
            r_b1_abs  <= n_abs;
            r_b2_sum  <= r_b1_sum;
            r_b2_neg  <= r_b1_neg;
            r_b2_alow <= r_b1_abs[idpr_pkg::REM_W-1:0];
            r_b2_q0   <= n_q0[idpr_pkg::REM_W-1:0];
            r_b3_sum  <= r_b2_sum;
            r_b3_neg  <= r_b2_neg;
            r_b3_rem  <= n_rem;
            r_b3_q0   <= r_b2_q0[idpr_pkg::QUANT_W-1:0];
            r_out.row_sum       <= r_b3_sum;
            r_out.row_quantized <= n_quant;
        end
    end

endmodule

// File: rtl/int8_dot_product_requantize_unit.sv
// Accepts one item per cycle while full is low: a pack of LANES signed int8 matrix and vector
// elements. The front end registers the lane products, then the pack sum, and adds it to a 32-bit
// wrapping row accumulator. An item marked last in row sends the row total into a four-entry queue
// and clears the accumulator; items not last in row produce no result. The back end divides the
// total by 127 toward zero in four registered steps and presents the row sum and the quotient's
// low eight bits on the result ports. Both sides sustain one item per cycle, the front while full
// is low and the back while results are popped as they appear; full rises only while a finished
// row waits for room in the queue.
`timescale 1ns / 1ps
`include "int8_dot_product_requantize_unit_macros.svh"

module int8_dot_product_requantize_unit #(
    parameter int LANES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  idpr_pkg::t_in_item   i_in_item,
    output logic                 o_full,
    output logic                 o_empty,
    input  logic                 i_pop,
    output idpr_pkg::t_out_item  o_out_item
);

    idpr_pkg::t_row_wr                  w_wr;
    idpr_pkg::t_fifo_status             w_fifo_status;
    logic signed [idpr_pkg::ACC_W-1:0]  w_fifo_sum;
    logic                               w_fifo_pop;

    // accumulate packs into row totals
    idpr_front #(
        .LANES (LANES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_in_item),
        .i_fifo_full (w_fifo_status.full),
        .o_full      (o_full),
        .o_wr        (w_wr)
    );

    // row totals waiting for the divider
    idpr_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_pop     (w_fifo_pop),
        .o_status  (w_fifo_status),
        .o_row_sum (w_fifo_sum)
    );

    // requantize and hold the result
    idpr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_status (w_fifo_status),
        .i_row_sum     (w_fifo_sum),
        .i_pop         (i_pop),
        .o_fifo_pop    (w_fifo_pop),
        .o_empty       (o_empty),
        .o_item        (o_out_item)
    );

    // checks
    `IDPR_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, w_wr.push, !w_fifo_status.full)
    `IDPR_ASSERT_NOW(a_full_means_queue_full, i_clk, i_rst_n, o_full, w_fifo_status.full)
    `IDPR_ASSERT_NEXT(a_stalled_row_kept, i_clk, i_rst_n, o_full, w_wr.push || o_full)
    `IDPR_ASSERT_NOW(a_small_sum_zero_quot, i_clk, i_rst_n, !o_empty && o_out_item.row_sum > -32'sd127 && o_out_item.row_sum < 32'sd127, o_out_item.row_quantized == 8'sd0)

endmodule

// File: verif/tb_int8_dot_product_requantize_unit.sv
// testbench for int8_dot_product_requantize_unit: queue-style driver, monitor and row predictor
// depends on idpr_pkg and the unit's top level only
`timescale 1ns / 1ps

module tb_int8_dot_product_requantize_unit;
    import idpr_pkg::*;

    localparam int LANE_COUNT     = 8;
    localparam int RANDOM_ITEMS   = 440;
    localparam int LONG_ROW_PACKS = 100;
    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_push = 1'b0;
    logic      i_pop = 1'b0;
    t_in_item  i_in_item = '0;
    logic      o_full;
    logic      o_empty;
    t_out_item o_out_item;

    // stimulus and scoreboard state
    t_in_item                pending_items[$];
    t_out_item               expected_rows[$];
    logic signed [ACC_W-1:0] row_total = '0;
    int                      queued_total = 0;
    int                      accepted_total = 0;
    int                      mismatch_count = 0;
    int                      quiet_cycles = 0;
    int                      idle_pct = 0;
    int                      stall_pct = 0;
    logic                    in_taken = 1'b0;

    int8_dot_product_requantize_unit #(
        .LANES(LANE_COUNT)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in_item (i_in_item),
        .o_full    (o_full),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_out_item(o_out_item)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // add one item to the row total; a last item closes the row into an expected result
    function automatic void predict_row_item(t_in_item it);
        logic signed [ACC_W-1:0]   total;
        logic signed [ACC_W-1:0]   quotient;
        logic signed [ELEM_W-1:0]  m;
        logic signed [ELEM_W-1:0]  v;
        t_out_item                 res;
        total = row_total;
        for (int k = 0; k < LANE_COUNT; k++) begin
            m = it.matrix_pack[ELEM_W*k +: ELEM_W];
            v = it.vector_pack[ELEM_W*k +: ELEM_W];
            total = total + m * v;
        end
        if (it.last_in_row) begin
            quotient = total / DIVISOR;
            res.row_sum = total;
            res.row_quantized = quotient[QUANT_W-1:0];
            expected_rows.push_back(res);
            row_total = '0;
        end else begin
            row_total = total;
        end
    endfunction

    // pack with a single live lane, the rest zero
    function automatic t_in_item one_lane(int lane, logic [7:0] m, logic [7:0] v, logic last);
        t_in_item it;
        it = '0;
        it.matrix_pack[ELEM_W*lane +: ELEM_W] = m;
        it.vector_pack[ELEM_W*lane +: ELEM_W] = v;
        it.last_in_row = last;
        return it;
    endfunction

    function automatic t_in_item full_pack(logic [7:0] m, logic [7:0] v, logic last);
        t_in_item it;
        it.matrix_pack = {8{m}};
        it.vector_pack = {8{v}};
        it.last_in_row = last;
        return it;
    endfunction

    // lane values lean toward the extremes
    function automatic logic [7:0] pick_lane();
        case ($urandom_range(5))
            0: return 8'h80;
            1: return 8'h7f;
            2: return 8'hff;
            3: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [PACK_W-1:0] pick_pack();
        logic [PACK_W-1:0] p;
        if ($urandom_range(3) == 0) begin
            p = {$urandom, $urandom};
        end else begin
            for (int k = 0; k < MAX_LANES; k++) p[ELEM_W*k +: ELEM_W] = pick_lane();
        end
        return p;
    endfunction

    task automatic queue_item(t_in_item it);
        pending_items.push_back(it);
        queued_total++;
    endtask

    // whole rows of random length, mostly short
    task automatic queue_random_rows(int n_items);
        int added;
        int row_len;
        t_in_item it;
        added = 0;
        while (added < n_items) begin
            case ($urandom_range(19))
                0: row_len = $urandom_range(60, 20);
                1, 2, 3, 4: row_len = $urandom_range(12, 5);
                default: row_len = $urandom_range(4, 1);
            endcase
            for (int r = 0; r < row_len; r++) begin
                it.matrix_pack = pick_pack();
                it.vector_pack = pick_pack();
                it.last_in_row = (r == row_len - 1);
                queue_item(it);
            end
            added += row_len;
        end
    endtask

    task automatic queue_directed();
        queue_item('0 | t_in_item'({128'b0, 1'b1}));
        queue_item(full_pack(8'h80, 8'h80, 1'b1));
        queue_item(full_pack(8'h80, 8'h7f, 1'b1));
        queue_item(full_pack(8'h7f, 8'h7f, 1'b1));
        // quotient boundaries around plus and minus one
        queue_item(one_lane(0, 8'd127, 8'd1, 1'b1));
        queue_item(one_lane(0, -8'sd127, 8'd1, 1'b1));
        queue_item(one_lane(0, 8'd126, 8'd1, 1'b1));
        queue_item(one_lane(0, -8'sd126, 8'd1, 1'b1));
        // quotient at the int8 minimum and just past the int8 maximum
        queue_item(one_lane(0, 8'h7f, 8'h80, 1'b1));
        queue_item(one_lane(0, 8'h80, 8'h81, 1'b1));
        // each lane alone, so lane order shows up
        for (int k = 0; k < MAX_LANES; k++) queue_item(one_lane(k, 8'h80, 8'(k + 1), 1'b1));
        // a short row spread over three items
        queue_item(full_pack(8'h7f, 8'h80, 1'b0));
        queue_item(one_lane(3, 8'hff, 8'h01, 1'b0));
        queue_item(full_pack(8'h01, 8'hff, 1'b1));
    endtask

    // one long row of extreme packs, a large sum with a wrapped quotient
    task automatic queue_long_row();
        for (int r = 0; r < LONG_ROW_PACKS; r++)
            queue_item(full_pack(8'h80, 8'h80, r == LONG_ROW_PACKS - 1));
    endtask

    // driver: hold the item until taken, then offer the next one or idle
    always @(negedge i_clk) begin
        t_in_item next_item;
        logic     next_push;
        next_item = i_in_item;
        next_push = i_push;
        if (!i_push || in_taken) begin
            next_push = 1'b0;
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                next_item = pending_items.pop_front();
                next_push = 1'b1;
            end
        end
        i_push <= next_push;
        i_in_item <= next_item;
        i_pop <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge i_clk) begin
        t_out_item want;
        logic      any_fire;
        any_fire = 1'b0;
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                predict_row_item(i_in_item);
                accepted_total++;
                any_fire = 1'b1;
            end
            if (i_pop && !o_empty) begin
                any_fire = 1'b1;
                if (expected_rows.size() == 0) begin
                    report_mismatch("result with no row pending, row_sum",
                                    o_out_item.row_sum, 0);
                end else begin
                    want = expected_rows.pop_front();
                    if (o_out_item.row_sum !== want.row_sum)
                        report_mismatch("row_sum", o_out_item.row_sum, want.row_sum);
                    if (o_out_item.row_quantized !== want.row_quantized)
                        report_mismatch("row_quantized", o_out_item.row_quantized,
                                        want.row_quantized);
                end
            end
            // watchdog on cycles with no handshake on either side
            quiet_cycles = any_fire ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[int8_dot_product_requantize_unit] ERROR");
                $finish;
            end
        end
        in_taken <= i_rst_n && i_push && !o_full;
    end

    // phases: no idling, sender idle, receiver stall, both
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            if (phase == 0) begin
                queue_directed();
                queue_long_row();
            end
            queue_random_rows(RANDOM_ITEMS);
            while (accepted_total != queued_total || expected_rows.size() != 0)
                @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_rows.size() != 0)
            report_mismatch("rows never delivered", 0, expected_rows.size());
        if (mismatch_count == 0) begin
            $display("[int8_dot_product_requantize_unit] OK");
        end else begin
            $display("[int8_dot_product_requantize_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/idpr_pkg.sv
rtl/idpr_front.sv
rtl/idpr_fifo.sv
rtl/idpr_back.sv
rtl/int8_dot_product_requantize_unit.sv
verif/tb_int8_dot_product_requantize_unit.sv
